// ----- hdl/pwts_pkg.sv -----
// Shared types and constants for the perspective world-to-screen block.
// Used by every module in hdl/; depends on nothing.
`default_nettype none

package pwts_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int REG_COUNT     = 7;
  localparam int ADDR_W        = 6;
  localparam int DATA_W        = 64;
  // Quotient bits of the normalized coordinate; its limit is 2^(QW-1).
  localparam int QW            = 34;
  localparam int SIZE_W        = 16;

  typedef enum logic [2:0] {
    REG_ROW0_C01 = 3'd0,
    REG_ROW0_C23 = 3'd1,
    REG_ROW1_C01 = 3'd2,
    REG_ROW1_C23 = 3'd3,
    REG_ROW3_C01 = 3'd4,
    REG_ROW3_C23 = 3'd5,
    REG_SCREEN   = 3'd6
  } reg_idx_e;

  localparam logic [DATA_W-1:0] REG_RESET [REG_COUNT] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd281474976710656, 64'd70780800
  };

  typedef struct packed {
    logic signed [31:0] c3;
    logic signed [31:0] c2;
    logic signed [31:0] c1;
    logic signed [31:0] c0;
  } row_t;

  typedef struct packed {
    row_t              row0;
    row_t              row1;
    row_t              row3;
    logic [SIZE_W-1:0] scr_w;
    logic [SIZE_W-1:0] scr_h;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/pwts_cfg.sv -----
// APB register file holding the matrix rows and the viewport size.
// Depends on pwts_pkg.
`default_nettype none

module pwts_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pwts_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pwts_pkg::DATA_W-1:0]   pwdata,
  output logic      [pwts_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output pwts_pkg::cfg_t                     cfg_o
);

  logic [pwts_pkg::DATA_W-1:0] regs_q [pwts_pkg::REG_COUNT];
  logic [2:0]                  idx;
  logic                        wr_en;

  assign idx    = paddr[5:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pwts_pkg::REG_COUNT; i++) regs_q[i] <= pwts_pkg::REG_RESET[i];
    end else if (wr_en && (idx < 3'(pwts_pkg::REG_COUNT))) begin
      if (idx == pwts_pkg::REG_SCREEN) begin
        regs_q[idx] <= {32'd0, pwdata[31:0]};
      end else begin
        regs_q[idx] <= pwdata;
      end
    end
  end

  always_comb begin
    if (idx < 3'(pwts_pkg::REG_COUNT)) prdata = regs_q[idx];
    else                               prdata = '0;
  end

  assign cfg_o.row0  = {regs_q[pwts_pkg::REG_ROW0_C23], regs_q[pwts_pkg::REG_ROW0_C01]};
  assign cfg_o.row1  = {regs_q[pwts_pkg::REG_ROW1_C23], regs_q[pwts_pkg::REG_ROW1_C01]};
  assign cfg_o.row3  = {regs_q[pwts_pkg::REG_ROW3_C23], regs_q[pwts_pkg::REG_ROW3_C01]};
  assign cfg_o.scr_w = regs_q[pwts_pkg::REG_SCREEN][15:0];
  assign cfg_o.scr_h = regs_q[pwts_pkg::REG_SCREEN][31:16];

endmodule

`default_nettype wire

// ----- hdl/pwts_dot.sv -----
// Three-stage dot-product pipeline: products, row sums, then sign/magnitude
// and depth clamp. Depends on pwts_pkg.
`default_nettype none

module pwts_dot #(
  parameter int FRAC_BITS = pwts_pkg::FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     adv_i,
  input  wire logic                     valid_i,
  input  wire logic signed [31:0]       x_i,
  input  wire logic signed [31:0]       y_i,
  input  wire logic signed [31:0]       z_i,
  input  pwts_pkg::cfg_t                cfg_i,
  output logic                          valid_o,
  output logic                          negx_o,
  output logic [63-FRAC_BITS:0]         magx_o,
  output logic                          negy_o,
  output logic [63-FRAC_BITS:0]         magy_o,
  output logic [63-FRAC_BITS:0]         depth_o
);

  localparam int DW       = 64 - FRAC_BITS;
  localparam int CW       = DW + 1;
  localparam int DMIN_RAW = ((1 << FRAC_BITS) + 500) / 1000;
  localparam int DMIN     = (DMIN_RAW < 1) ? 1 : DMIN_RAW;

  logic [2:0]         vld_q;
  logic signed [63:0] prod_q [9];
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic signed [CW-1:0] cx_d, cy_d, cz_d;
  logic signed [31:0] tx_q, ty_q, tz_q;

  function automatic logic signed [CW-1:0] row_sum(
    input logic signed [63:0] p0, input logic signed [63:0] p1,
    input logic signed [63:0] p2, input logic signed [31:0] t);
    logic signed [65:0] s;
    logic signed [65:0] sh;
    s  = 66'(p0) + 66'(p1) + 66'(p2);
    sh = s >>> FRAC_BITS;
    return CW'(sh) + CW'(t);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv_i) vld_q <= {vld_q[1:0], valid_i};
  end

  // Products and translation terms.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q[0] <= 64'(cfg_i.row0.c0) * 64'(x_i);
      prod_q[1] <= 64'(cfg_i.row0.c1) * 64'(y_i);
      prod_q[2] <= 64'(cfg_i.row0.c2) * 64'(z_i);
      prod_q[3] <= 64'(cfg_i.row1.c0) * 64'(x_i);
      prod_q[4] <= 64'(cfg_i.row1.c1) * 64'(y_i);
      prod_q[5] <= 64'(cfg_i.row1.c2) * 64'(z_i);
      prod_q[6] <= 64'(cfg_i.row3.c0) * 64'(x_i);
      prod_q[7] <= 64'(cfg_i.row3.c1) * 64'(y_i);
      prod_q[8] <= 64'(cfg_i.row3.c2) * 64'(z_i);
      tx_q      <= cfg_i.row0.c3;
      ty_q      <= cfg_i.row1.c3;
      tz_q      <= cfg_i.row3.c3;
    end
  end

  assign cx_d = row_sum(prod_q[0], prod_q[1], prod_q[2], tx_q);
  assign cy_d = row_sum(prod_q[3], prod_q[4], prod_q[5], ty_q);
  assign cz_d = row_sum(prod_q[6], prod_q[7], prod_q[8], tz_q);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      cz_q <= cz_d;
    end
  end

  // Split sign from magnitude; hold the depth at its floor.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      negx_o  <= cx_q[CW-1];
      magx_o  <= cx_q[CW-1] ? DW'(-cx_q) : DW'(cx_q);
      negy_o  <= cy_q[CW-1];
      magy_o  <= cy_q[CW-1] ? DW'(-cy_q) : DW'(cy_q);
      depth_o <= (cz_q < $signed(CW'(DMIN))) ? DW'(DMIN) : DW'(cz_q);
    end
  end

  assign valid_o = vld_q[2];

endmodule

`default_nettype wire

// ----- hdl/pwts_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, giving
// min(mag * 2^F / den, 2^(QW-1)). Depends on pwts_pkg.
`default_nettype none

module pwts_div #(
  parameter int FRAC_BITS = pwts_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      adv_i,
  input  wire logic                      valid_i,
  input  wire logic                      neg_i,
  input  wire logic [63-FRAC_BITS:0]     mag_i,
  input  wire logic [63-FRAC_BITS:0]     den_i,
  output logic                           valid_o,
  output logic                           neg_o,
  output logic [pwts_pkg::QW-1:0]        quot_o
);

  localparam int DW = 64 - FRAC_BITS;
  localparam int QW = pwts_pkg::QW;
  localparam logic [QW-1:0] NORM_LIMIT = QW'(1) << (QW - 1);

  logic [QW:0]   vld_q;
  logic [QW:0]   neg_q;
  logic [QW:0]   ovf_q;
  logic [DW-1:0] rem_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] low_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [DW-1:0] head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv_i) vld_q <= {vld_q[QW-1:0], valid_i};
  end

  // Leading dividend bits seed the remainder; a quotient at or past
  // 2^QW flags overflow right away.
  assign head = DW'(mag_i >> (QW - FRAC_BITS));

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      neg_q[0] <= neg_i;
      ovf_q[0] <= (head >= den_i);
      rem_q[0] <= head;
      den_q[0] <= den_i;
      low_q[0] <= QW'(mag_i) << FRAC_BITS;
      quo_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] nrem;

    assign trial = {rem_q[i], low_q[i][QW-1]};
    assign ge    = trial >= {1'b0, den_q[i]};
    assign nrem  = ge ? DW'(trial - {1'b0, den_q[i]}) : DW'(trial);

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        neg_q[i+1] <= neg_q[i];
        ovf_q[i+1] <= ovf_q[i];
        rem_q[i+1] <= nrem;
        den_q[i+1] <= den_q[i];
        low_q[i+1] <= low_q[i] << 1;
        quo_q[i+1] <= {quo_q[i][QW-2:0], ge};
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign neg_o   = neg_q[QW];
  assign quot_o  = (ovf_q[QW] || (quo_q[QW] > NORM_LIMIT)) ? NORM_LIMIT : quo_q[QW];

endmodule

`default_nettype wire

// ----- hdl/perspective_world_to_screen.sv -----
// Top level of the perspective world-to-screen projector.
// Depends on pwts_pkg, pwts_cfg, pwts_dot and pwts_div.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one world point
//   world_x_i, world_y_i, world_z_i in signed Q.FRAC_BITS. The output
//   channel (out_valid_o / out_stall_i) carries screen_x_o, screen_y_o
//   (signed Q.FRAC_BITS, saturated) and on_screen_o. An item moves on a
//   rising edge with valid high and stall low.
//   The path has 3 dot-product stages, 35 divider stages (a seed
//   stage, then one quotient bit per stage, both coordinates in parallel),
//   one viewport multiply stage and the output register. Throughput is one
//   item per cycle whenever the output side is not stalling a valid result.
//   When the receiver stalls a valid output, the whole pipeline freezes and
//   in_stall_o rises in the same cycle; bubbles and results are held, none
//   dropped or repeated. An output slot that is empty never stalls input.
//   Reset clears every valid bit and loads the default matrix (identity on
//   rows 0, 1 and 3) and a 1920 x 1080 viewport.
//   Configuration goes through the APB port (64-bit data, register i at
//   byte address 8*i) while no item is in flight.
`default_nettype none

module perspective_world_to_screen #(
  parameter int FRAC_BITS = pwts_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pwts_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pwts_pkg::DATA_W-1:0]   pwdata,
  output logic      [pwts_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [31:0]            world_x_i,
  input  wire logic signed [31:0]            world_y_i,
  input  wire logic signed [31:0]            world_z_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [31:0]                 screen_x_o,
  output logic signed [31:0]                 screen_y_o,
  output logic                               on_screen_o
);

  localparam int DW = 64 - FRAC_BITS;
  localparam int QW = pwts_pkg::QW;
  localparam int SZ = pwts_pkg::SIZE_W;
  localparam int PW = QW + SZ;      // quotient times size
  localparam int OW = PW - 1;       // after the halving
  localparam int SW = OW + 2;       // signed screen coordinate

  pwts_pkg::cfg_t cfg;
  logic           adv;

  logic          dot_vld, dot_negx, dot_negy;
  logic [DW-1:0] dot_magx, dot_magy, dot_depth;

  logic          vx, vy, nx, ny;
  logic [QW-1:0] qx, qy;

  logic          map_vld_q, map_nx_q, map_ny_q;
  logic [OW-1:0] offx_q, offy_q;
  logic [PW-1:0] prodx, prody;

  logic signed [SW-1:0] cen_x, cen_y, lim_x, lim_y, sx, sy;
  logic                 on_d;
  logic                 out_vld_q, on_q;
  logic signed [31:0]   scr_x_q, scr_y_q;

  pwts_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Freeze everything while a finished item waits at a stalled output.
  assign adv        = !(out_vld_q && out_stall_i);
  assign in_stall_o = !adv;

  pwts_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .x_i     (world_x_i),
    .y_i     (world_y_i),
    .z_i     (world_z_i),
    .cfg_i   (cfg),
    .valid_o (dot_vld),
    .negx_o  (dot_negx),
    .magx_o  (dot_magx),
    .negy_o  (dot_negy),
    .magy_o  (dot_magy),
    .depth_o (dot_depth)
  );

  pwts_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (dot_vld),
    .neg_i   (dot_negx),
    .mag_i   (dot_magx),
    .den_i   (dot_depth),
    .valid_o (vx),
    .neg_o   (nx),
    .quot_o  (qx)
  );

  pwts_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (dot_vld),
    .neg_i   (dot_negy),
    .mag_i   (dot_magy),
    .den_i   (dot_depth),
    .valid_o (vy),
    .neg_o   (ny),
    .quot_o  (qy)
  );

  // Scale the normalized coordinate by half the viewport size.
  assign prodx = PW'(qx) * PW'(cfg.scr_w);
  assign prody = PW'(qy) * PW'(cfg.scr_h);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) map_vld_q <= 1'b0;
    else if (adv) map_vld_q <= vx;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      map_nx_q <= nx;
      map_ny_q <= ny;
      offx_q   <= OW'(prodx >> 1);
      offy_q   <= OW'(prody >> 1);
    end
  end

  // Centre plus offset for x, centre minus offset for y (y points down); a negative coordinate flips its offset.
  assign cen_x = $signed(SW'(cfg.scr_w) << (FRAC_BITS - 1));
  assign cen_y = $signed(SW'(cfg.scr_h) << (FRAC_BITS - 1));
  assign lim_x = $signed(SW'(cfg.scr_w) << FRAC_BITS);
  assign lim_y = $signed(SW'(cfg.scr_h) << FRAC_BITS);
  assign sx    = map_nx_q ? cen_x - $signed(SW'(offx_q)) : cen_x + $signed(SW'(offx_q));
  assign sy    = map_ny_q ? cen_y + $signed(SW'(offy_q)) : cen_y - $signed(SW'(offy_q));
  assign on_d  = (sx > 0) && (sx < lim_x) && (sy > 0) && (sy < lim_y);

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    logic [SW-32:0] hi;
    hi = v[SW-1:31];
    if ((hi == '0) || (hi == '1)) return v[31:0];
    return v[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= map_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      scr_x_q <= sat32(sx);
      scr_y_q <= sat32(sy);
      on_q    <= on_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign screen_x_o  = scr_x_q;
  assign screen_y_o  = scr_y_q;
  assign on_screen_o = on_q;

  // Both divider lanes carry the same item stream.
  a_lanes_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vx == vy) else $error("divider lanes out of step");

  // An on-screen point has strictly positive coordinates.
  a_on_positive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && on_screen_o) |-> (screen_x_o > 0) && (screen_y_o > 0))
    else $error("on-screen point with non-positive coordinate");

  // A zero-size viewport never reports a point on screen.
  a_on_needs_size : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && on_screen_o) |-> (cfg.scr_w != '0) && (cfg.scr_h != '0))
    else $error("on-screen flag with empty viewport");

endmodule

`default_nettype wire
